### rtl/lbb_pkg.sv
package lbb_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_ADDR_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ON_HOLD       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFF_HOLD      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BLINK_COUNT   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP           = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_UP       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_DOWN_END = 3'd6;

  // Pattern modes.
  localparam logic [1:0] MODE_BLINK_N      = 2'd0;
  localparam logic [1:0] MODE_BLINK_ALWAYS = 2'd1;
  localparam logic [1:0] MODE_BLINK_GAP    = 2'd2;
  localparam logic [1:0] MODE_BREATHE      = 2'd3;

  // Switch commands.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic [7:0] PULSE_MAX = 8'd255;

  // Register values after reset.
  localparam logic [1:0]  RST_MODE          = MODE_BLINK_N;
  localparam logic [15:0] RST_ON_HOLD       = 16'd500;
  localparam logic [15:0] RST_OFF_HOLD      = 16'd500;
  localparam logic [7:0]  RST_BLINK_COUNT   = 8'd3;
  localparam logic [15:0] RST_GAP           = 16'd2000;
  localparam logic [15:0] RST_RAMP_UP       = 16'd1000;
  localparam logic [15:0] RST_RAMP_DOWN_END = 16'd3000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] on_hold_ms;
    logic [15:0] off_hold_ms;
    logic [7:0]  blink_count;
    logic [15:0] gap_ms;
    logic [15:0] ramp_up_ms;
    logic [15:0] ramp_down_end_ms;
  } cfg_t;

  // Write events that also touch the pattern state.
  typedef struct packed {
    logic       mode_wr;
    logic       count_wr;
    logic [1:0] mode;
    logic [7:0] count;
  } cfg_ev_t;

  typedef struct packed {
    logic [1:0] switch_cmd;
    logic       duty_valid;
    logic [7:0] duty;
  } res_t;

endpackage

### rtl/led_blink_breathe_pattern.sv
// LED blink and breathe pattern generator.
// Each word on the input stream is one service call carrying the current
// millisecond time; each call gives exactly one result word on the output
// stream with the switch command, and in breathe mode the duty level.
// The configuration channel writes one register per handshake; cfg_ready is
// always high. The user must write registers only while no call is in flight;
// the block does not enforce this. An accepted call is held in an input
// register, evaluated against the pattern state once the result register
// is free or being taken, and captured there. One call is taken every cycle
// unless the output stalls; the limit is the single state update per call.
// When the receiver stalls the result register holds its word, the input
// register fills and in_tready drops until the result is taken.
// Reset brings all registers to their defaults (blink three times, 500 ms on
// and off) with the LED pattern at the start of the on phase.
module led_blink_breathe_pattern #(
  parameter logic [7:0] PULSE_MAX = lbb_pkg::PULSE_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lbb_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] now_ms
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lbb_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] switch_cmd, [9:2] duty, zero pad
  output logic                           out_tuser,  // [0] duty_valid
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbb_pkg::*;

  cfg_t    cfg;
  cfg_ev_t ev;
  res_t    res;

  logic        in_valid_r;
  logic [31:0] now_r;
  logic        advance;
  logic        out_valid_r;
  res_t        out_res_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      now_r <= in_tdata;
    end
  end

  lbb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .ev        (ev)
  );

  lbb_core #(
    .PULSE_MAX (PULSE_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ev         (ev),
    .item_valid (advance),
    .now_ms     (now_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.duty, out_res_r.switch_cmd};
  assign out_tuser  = out_res_r.duty_valid;

endmodule

### rtl/lbb_cfg_regs.sv
module lbb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbb_pkg::CFG_DATA_W-1:0] cfg_data,
  output lbb_pkg::cfg_t                  cfg,
  output lbb_pkg::cfg_ev_t               ev
);
  import lbb_pkg::*;

  cfg_t cfg_r;
  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;
  assign cfg       = cfg_r;

  assign ev.mode_wr  = wr && (cfg_addr == REG_MODE);
  assign ev.count_wr = wr && (cfg_addr == REG_BLINK_COUNT);
  assign ev.mode     = cfg_data[1:0];
  assign ev.count    = cfg_data[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= RST_MODE;
      cfg_r.on_hold_ms       <= RST_ON_HOLD;
      cfg_r.off_hold_ms      <= RST_OFF_HOLD;
      cfg_r.blink_count      <= RST_BLINK_COUNT;
      cfg_r.gap_ms           <= RST_GAP;
      cfg_r.ramp_up_ms       <= RST_RAMP_UP;
      cfg_r.ramp_down_end_ms <= RST_RAMP_DOWN_END;
    end else if (wr) begin
      case (cfg_addr)
        REG_MODE:          cfg_r.mode             <= cfg_data[1:0];
        REG_ON_HOLD:       cfg_r.on_hold_ms       <= cfg_data;
        REG_OFF_HOLD:      cfg_r.off_hold_ms      <= cfg_data;
        REG_BLINK_COUNT:   cfg_r.blink_count      <= cfg_data[7:0];
        REG_GAP:           cfg_r.gap_ms           <= cfg_data;
        REG_RAMP_UP:       cfg_r.ramp_up_ms       <= cfg_data;
        REG_RAMP_DOWN_END: cfg_r.ramp_down_end_ms <= cfg_data;
        default:           ;
      endcase
    end
  end

endmodule

### rtl/lbb_core.sv
module lbb_core #(
  parameter logic [7:0] PULSE_MAX = lbb_pkg::PULSE_MAX
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lbb_pkg::cfg_t    cfg,
  input  lbb_pkg::cfg_ev_t ev,
  input  logic             item_valid,
  input  logic [31:0]      now_ms,
  output lbb_pkg::res_t    res
);
  import lbb_pkg::*;

  logic        led_phase_r, led_phase_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] phase_start_r, phase_start_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        gap_active_r, gap_active_nxt;
  logic [31:0] gap_start_r, gap_start_nxt;

  logic [31:0] elapsed;
  logic [31:0] gap_elapsed;
  logic [16:0] up_hold_end;
  logic [16:0] dark_end;
  logic        counted;
  logic        run_blink;

  assign elapsed     = now_ms - phase_start_r;
  assign gap_elapsed = now_ms - gap_start_r;
  assign up_hold_end = {1'b0, cfg.ramp_up_ms} + {1'b0, cfg.on_hold_ms};
  assign dark_end    = {1'b0, cfg.ramp_down_end_ms} + {1'b0, cfg.off_hold_ms};
  assign counted     = (cfg.mode != MODE_BLINK_ALWAYS);
  assign run_blink   = (cfg.mode == MODE_BLINK_N) || (cfg.mode == MODE_BLINK_ALWAYS) ||
                       ((cfg.mode == MODE_BLINK_GAP) && !gap_active_r);

  always_comb begin
    led_phase_nxt   = led_phase_r;
    armed_nxt       = armed_r;
    phase_start_nxt = phase_start_r;
    level_nxt       = level_r;
    gap_active_nxt  = gap_active_r;
    gap_start_nxt   = gap_start_r;
    res.switch_cmd  = CMD_NONE;
    res.duty_valid  = 1'b0;
    res.duty        = 8'd0;

    // On/off phases; a spent counter freezes the blink sequence.
    if (run_blink && !(counted && (level_r == 8'd0))) begin
      if (!armed_r) begin
        res.switch_cmd  = led_phase_r ? CMD_OFF : CMD_ON;
        armed_nxt       = 1'b1;
        phase_start_nxt = now_ms;
      end else if (!led_phase_r) begin
        if (elapsed > {16'd0, cfg.on_hold_ms}) begin
          armed_nxt     = 1'b0;
          led_phase_nxt = 1'b1;
        end
      end else if (elapsed > {16'd0, cfg.off_hold_ms}) begin
        armed_nxt     = 1'b0;
        led_phase_nxt = 1'b0;
        if (counted) begin
          level_nxt = level_r - 8'd1;
        end
      end
    end

    if (cfg.mode == MODE_BLINK_GAP) begin
      if (!gap_active_r) begin
        if (level_nxt == 8'd0) begin
          gap_active_nxt = 1'b1;
          gap_start_nxt  = now_ms;
          level_nxt      = cfg.blink_count;
        end
      end else if (gap_elapsed > {16'd0, cfg.gap_ms}) begin
        gap_active_nxt = 1'b0;
      end
    end

    if (cfg.mode == MODE_BREATHE) begin
      if (elapsed < {16'd0, cfg.ramp_up_ms}) begin
        if (level_r < PULSE_MAX) begin
          level_nxt = level_r + 8'd1;
        end
        res.duty_valid = 1'b1;
        res.duty       = level_nxt;
      end else if (elapsed < {15'd0, up_hold_end}) begin
        level_nxt      = PULSE_MAX;
        res.duty_valid = 1'b1;
        res.duty       = PULSE_MAX;
      end else if (elapsed < {16'd0, cfg.ramp_down_end_ms}) begin
        if (level_r != 8'd0) begin
          level_nxt = level_r - 8'd1;
        end
        res.duty_valid = 1'b1;
        res.duty       = level_nxt;
      end else if (elapsed < {15'd0, dark_end}) begin
        res.duty_valid = 1'b1;
      end else begin
        phase_start_nxt = now_ms;
        level_nxt       = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_phase_r   <= 1'b0;
      armed_r       <= 1'b0;
      phase_start_r <= 32'd0;
      level_r       <= RST_BLINK_COUNT;
      gap_active_r  <= 1'b0;
      gap_start_r   <= 32'd0;
    end else if (ev.mode_wr) begin
      // A new mode starts the pattern from the top.
      led_phase_r   <= 1'b0;
      armed_r       <= 1'b0;
      phase_start_r <= 32'd0;
      level_r       <= (ev.mode == MODE_BREATHE) ? 8'd0 : cfg.blink_count;
      gap_active_r  <= 1'b0;
      gap_start_r   <= 32'd0;
    end else if (ev.count_wr) begin
      if (cfg.mode != MODE_BREATHE) begin
        level_r <= ev.count;
      end
    end else if (item_valid) begin
      led_phase_r   <= led_phase_nxt;
      armed_r       <= armed_nxt;
      phase_start_r <= phase_start_nxt;
      level_r       <= level_nxt;
      gap_active_r  <= gap_active_nxt;
      gap_start_r   <= gap_start_nxt;
    end
  end

  a_mode_wr_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ev.mode_wr |=> !armed_r && !led_phase_r && !gap_active_r && (phase_start_r == 32'd0))
    else $error("mode write did not restart the pattern");

  a_duty_only_breathe: assert property (@(posedge clk) disable iff (!rst_n)
    res.duty_valid |-> (cfg.mode == MODE_BREATHE) && (res.switch_cmd == CMD_NONE))
    else $error("duty set outside breathe mode");

  a_gap_only_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (!gap_active_r && (cfg.mode != MODE_BLINK_GAP)) |=> !gap_active_r)
    else $error("gap entered outside cycle mode");

  a_cmd_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !ev.mode_wr && !ev.count_wr && (res.switch_cmd != CMD_NONE)) |=> armed_r)
    else $error("switch command issued without arming the phase");

endmodule
